// ===== design/lfu_pkg.sv =====
package lfu_pkg;

    // fixed field widths of the request and result items
    localparam int PAGE_IN_W  = 32;
    localparam int OUT_IDX_W  = 3;
    localparam int COUNT_W    = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

    typedef logic [PAGE_IN_W-1:0] page_in_t;
    typedef logic [OUT_IDX_W-1:0] out_idx_t;
    typedef logic [COUNT_W-1:0]   count_t;

endpackage

// ===== design/lfu_if.sv =====
interface lfu_req_if;
    import lfu_pkg::*;

    logic     valid;
    logic     ready;
    page_in_t page_address;

    modport source (output valid, output page_address, input ready);
    modport sink   (input valid, input page_address, output ready);
endinterface

interface lfu_resp_if;
    import lfu_pkg::*;

    logic     valid;
    logic     ready;
    out_idx_t frame_index;
    logic     hit;
    logic     took_empty_frame;
    count_t   new_count;

    modport source (output valid, output frame_index, output hit,
                    output took_empty_frame, output new_count, input ready);
    modport sink   (input valid, input frame_index, input hit,
                    input took_empty_frame, input new_count, output ready);
endinterface

// ===== design/lfu_avg_div.sv =====
module lfu_avg_div #(
    parameter int FRAMES = 8
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              start,
    input  logic [lfu_pkg::COUNT_W+$clog2(FRAMES)-1:0]        dividend,
    output logic                                              done,
    output lfu_pkg::count_t                                   quotient
);
    import lfu_pkg::*;

    // floor(n / (FRAMES-1)) as n * ceil(2^S / D) >> S, exact for n < 2^SUM_W
    localparam int SUM_W   = COUNT_W + $clog2(FRAMES);
    localparam int DIVISOR = FRAMES - 1;
    localparam int SHIFT   = SUM_W + $clog2(DIVISOR);
    localparam logic [63:0] MULT_FULL =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam int MULT_W  = SUM_W + 1;
    localparam int PROD_W  = SUM_W + MULT_W;
    localparam logic [MULT_W-1:0] MULT = MULT_FULL[MULT_W-1:0];

    logic [PROD_W-1:0] prod_reg;
    logic              done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= PROD_W'(dividend) * PROD_W'(MULT);
        end
    end

    assign done     = done_reg;
    assign quotient = prod_reg[SHIFT+COUNT_W-1:SHIFT];

endmodule

// ===== design/lfu_page_frame_replacement_core.sv =====
// lfu page frame table
//
// req (sink) carries one page request item; resp (source) returns one result
// item per request: the frame that now holds the page, hit, whether a miss
// took an empty frame, and the use count stored there.
// a request is taken only while the sequencer is idle. the table is scanned
// one frame a cycle through a single read port of the page and count stores;
// on an eviction the average of the other counts goes through a registered
// reciprocal multiply before the result is written. the next request is
// taken only after the sequencer has finished the last one and gone idle.
// the result sits in an output register; a new request is taken while it
// waits, and a finished request holds in its last state until the receiver
// has taken the previous result.
// reset empties every frame at once through per-frame valid bits; counts of
// empty frames read as zero, so no clearing pass is needed.
module lfu_page_frame_replacement_core #(
    parameter int FRAMES       = 8,
    parameter int ADDRESS_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    lfu_req_if.sink     req,
    lfu_resp_if.source  resp
);
    import lfu_pkg::*;

    localparam int IDX_W  = $clog2(FRAMES);
    localparam int CNT_W  = $clog2(FRAMES + 1);
    localparam int SUM_W  = COUNT_W + $clog2(FRAMES);
    localparam int KEEP_W = (ADDRESS_BITS < PAGE_IN_W) ? ADDRESS_BITS : PAGE_IN_W;
    localparam int EXT_W  = (IDX_W > OUT_IDX_W) ? IDX_W : OUT_IDX_W;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_AVG    = 3'd3;
    localparam logic [2:0] S_DIVIDE = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [KEEP_W-1:0] addr_reg, addr_next;

    // scan accumulators
    logic              match_found_reg, match_found_next;
    logic [IDX_W-1:0]  match_idx_reg, match_idx_next;
    count_t            match_count_reg, match_count_next;
    logic              empty_found_reg, empty_found_next;
    logic [IDX_W-1:0]  empty_idx_reg, empty_idx_next;
    count_t            min_count_reg, min_count_next;
    logic [IDX_W-1:0]  victim_idx_reg, victim_idx_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;

    // decision
    logic [IDX_W-1:0]  chosen_idx_reg, chosen_idx_next;
    count_t            new_count_reg, new_count_next;
    logic              hit_res_reg, hit_res_next;
    logic              took_res_reg, took_res_next;
    logic              write_page_reg, write_page_next;

    logic [FRAMES-1:0] valid_reg, valid_next;

    // output register
    logic              resp_valid_reg, resp_valid_next;
    out_idx_t          frame_index_reg, frame_index_next;
    logic              hit_reg, hit_next;
    logic              took_empty_reg, took_empty_next;
    count_t            count_out_reg, count_out_next;

    // frame stores, one read port each
    logic [KEEP_W-1:0] page_mem [FRAMES];
    count_t            count_mem [FRAMES];
    logic [KEEP_W-1:0] page_rd_reg;
    count_t            count_rd_reg;

    logic [IDX_W-1:0]  issue_idx;
    logic [CNT_W-1:0]  proc_cnt;
    logic [IDX_W-1:0]  proc_idx;
    logic              proc_valid;
    count_t            proc_count;
    logic              out_free;
    logic              mem_we;
    logic [EXT_W-1:0]  idx_ext;

    logic              div_start;
    logic              div_done;
    count_t            div_quotient;

    lfu_avg_div #(.FRAMES(FRAMES)) u_avg_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign issue_idx  = cnt_reg[IDX_W-1:0];
    assign proc_cnt   = cnt_reg - CNT_W'(1);
    assign proc_idx   = proc_cnt[IDX_W-1:0];
    assign proc_valid = valid_reg[proc_idx];
    // an empty frame was never given a count, so it counts as zero
    assign proc_count = proc_valid ? count_rd_reg : '0;
    assign out_free   = !resp_valid_reg || resp.ready;
    assign mem_we     = (state_reg == S_FINISH) && out_free;
    assign div_start  = (state_reg == S_AVG);
    assign idx_ext    = EXT_W'(chosen_idx_reg);

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        addr_next        = addr_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        match_count_next = match_count_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        min_count_next   = min_count_reg;
        victim_idx_next  = victim_idx_reg;
        sum_next         = sum_reg;
        chosen_idx_next  = chosen_idx_reg;
        new_count_next   = new_count_reg;
        hit_res_next     = hit_res_reg;
        took_res_next    = took_res_reg;
        write_page_next  = write_page_reg;
        valid_next       = valid_reg;
        resp_valid_next  = resp_valid_reg;
        frame_index_next = frame_index_reg;
        hit_next         = hit_reg;
        took_empty_next  = took_empty_reg;
        count_out_next   = count_out_reg;

        if (resp_valid_reg && resp.ready)
        begin
            resp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    addr_next        = req.page_address[KEEP_W-1:0];
                    cnt_next         = '0;
                    match_found_next = 1'b0;
                    empty_found_next = 1'b0;
                    sum_next         = '0;
                    state_next       = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // reads issued at cnt, data of frame cnt-1 examined here
                if (cnt_reg != '0)
                begin
                    if (proc_valid)
                    begin
                        if (!match_found_reg && page_rd_reg == addr_reg)
                        begin
                            match_found_next = 1'b1;
                            match_idx_next   = proc_idx;
                            match_count_next = count_rd_reg;
                        end
                    end
                    else if (!empty_found_reg)
                    begin
                        empty_found_next = 1'b1;
                        empty_idx_next   = proc_idx;
                    end
                    if (proc_cnt == '0 || proc_count < min_count_reg)
                    begin
                        min_count_next  = proc_count;
                        victim_idx_next = proc_idx;
                    end
                    sum_next = sum_reg + SUM_W'(proc_count);
                end
                if (cnt_reg == CNT_W'(FRAMES))
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_DECIDE:
            begin
                priority if (match_found_reg)
                begin
                    chosen_idx_next = match_idx_reg;
                    new_count_next  = (match_count_reg == COUNT_MAX) ? COUNT_MAX
                                      : match_count_reg + COUNT_ONE;
                    hit_res_next    = 1'b1;
                    took_res_next   = 1'b0;
                    write_page_next = 1'b0;
                    state_next      = S_FINISH;
                end
                else if (empty_found_reg)
                begin
                    chosen_idx_next = empty_idx_reg;
                    new_count_next  = COUNT_ONE;
                    hit_res_next    = 1'b0;
                    took_res_next   = 1'b1;
                    write_page_next = 1'b1;
                    state_next      = S_FINISH;
                end
                else
                begin
                    // eviction: average over the frames that stay
                    chosen_idx_next = victim_idx_reg;
                    hit_res_next    = 1'b0;
                    took_res_next   = 1'b0;
                    write_page_next = 1'b1;
                    sum_next        = sum_reg - SUM_W'(min_count_reg);
                    state_next      = S_AVG;
                end
            end
            S_AVG:
            begin
                state_next = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                if (div_done)
                begin
                    new_count_next = div_quotient;
                    state_next     = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    resp_valid_next  = 1'b1;
                    frame_index_next = idx_ext[OUT_IDX_W-1:0];
                    hit_next         = hit_res_reg;
                    took_empty_next  = took_res_reg;
                    count_out_next   = new_count_reg;
                    if (write_page_reg)
                    begin
                        valid_next[chosen_idx_reg] = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            match_found_reg <= 1'b0;
            empty_found_reg <= 1'b0;
            valid_reg       <= '0;
            resp_valid_reg  <= 1'b0;
            hit_res_reg     <= 1'b0;
            took_res_reg    <= 1'b0;
            write_page_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            match_found_reg <= match_found_next;
            empty_found_reg <= empty_found_next;
            valid_reg       <= valid_next;
            resp_valid_reg  <= resp_valid_next;
            hit_res_reg     <= hit_res_next;
            took_res_reg    <= took_res_next;
            write_page_reg  <= write_page_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        addr_reg        <= addr_next;
        match_idx_reg   <= match_idx_next;
        match_count_reg <= match_count_next;
        empty_idx_reg   <= empty_idx_next;
        min_count_reg   <= min_count_next;
        victim_idx_reg  <= victim_idx_next;
        sum_reg         <= sum_next;
        chosen_idx_reg  <= chosen_idx_next;
        new_count_reg   <= new_count_next;
        frame_index_reg <= frame_index_next;
        hit_reg         <= hit_next;
        took_empty_reg  <= took_empty_next;
        count_out_reg   <= count_out_next;
    end

    // frame stores
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            count_mem[chosen_idx_reg] <= new_count_reg;
            if (write_page_reg)
            begin
                page_mem[chosen_idx_reg] <= addr_reg;
            end
        end
        page_rd_reg  <= page_mem[issue_idx];
        count_rd_reg <= count_mem[issue_idx];
    end

    assign req.ready             = (state_reg == S_IDLE);
    assign resp.valid            = resp_valid_reg;
    assign resp.frame_index      = frame_index_reg;
    assign resp.hit              = hit_reg;
    assign resp.took_empty_frame = took_empty_reg;
    assign resp.new_count        = count_out_reg;

    // a fill always starts the frame at one
    a_fill_count_one: assert property (@(posedge clk) disable iff (!rst_n)
        resp.valid && resp.took_empty_frame |-> resp.new_count == COUNT_ONE)
        else $error("fill result without count of one");

    // hit and fill exclude each other
    a_hit_not_fill: assert property (@(posedge clk) disable iff (!rst_n)
        resp.valid |-> !(resp.hit && resp.took_empty_frame))
        else $error("result marked both hit and fill");

    // the average only returns while the sequencer waits for it
    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIVIDE)
        else $error("average returned outside its wait state");

    // a miss leaves the chosen frame resident
    a_miss_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && write_page_reg |=> valid_reg[chosen_idx_reg])
        else $error("missed page not marked resident");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

// lfu frame table: every request item is predicted when it is accepted, and
// every result item is checked against the oldest prediction still waiting
module testbench;
    import lfu_pkg::*;

    localparam int FRAMES        = 8;
    localparam int STALL_LIMIT   = 3000;   // cycles with no handshake on either side
    localparam int DRAIN_CYCLES  = 40;     // well past the slowest eviction latency
    localparam int HOLD_OFF_LEN  = 300;    // long receiver hold-off for the pressure test
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 185;
    localparam int HOT_HITS      = 120;

    // one expected result item
    typedef struct packed {
        out_idx_t frame_index;
        logic     hit;
        logic     took_empty_frame;
        count_t   new_count;
    } frame_result_t;

    logic clk;
    logic rst_n;

    lfu_req_if  req_ch ();
    lfu_resp_if resp_ch ();

    lfu_page_frame_replacement_core #(
        .FRAMES       (FRAMES),
        .ADDRESS_BITS (PAGE_IN_W)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .resp  (resp_ch)
    );

    // shadow copy of the frame table
    bit       table_valid [FRAMES];
    page_in_t table_page  [FRAMES];
    count_t   table_count [FRAMES];

    frame_result_t frame_results_q[$];

    // random page pool, so that requests come back often enough to hit
    page_in_t page_pool [16];
    int       pool_n;

    bit idling_on;
    int hold_off_len;
    int error_count;
    int idle_cycles;
    int n_hits;
    int n_fills;
    int n_evictions;
    int n_saturated;

    // clock, 10 ns period
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // lfu lookup and update of the shadow table for one page request
    function automatic frame_result_t lookup_frame(page_in_t page);
        int            match;
        int            empty;
        int            victim;
        int unsigned   sum;
        frame_result_t res;
        match  = -1;
        empty  = -1;
        victim = 0;
        sum    = 0;
        res    = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (table_valid[i])
            begin
                if (match < 0 && table_page[i] == page)
                    match = i;
            end
            else if (empty < 0)
            begin
                empty = i;
            end
            // strict compare keeps the lowest index on a tie
            if (table_count[i] < table_count[victim])
                victim = i;
            sum += table_count[i];
        end
        if (match >= 0)
        begin
            res.frame_index = out_idx_t'(match);
            res.hit         = 1'b1;
            if (table_count[match] != COUNT_MAX)
                table_count[match] = table_count[match] + 1'b1;
            else
                n_saturated++;
            res.new_count = table_count[match];
        end
        else if (empty >= 0)
        begin
            // lowest empty frame, fresh count of one
            res.frame_index      = out_idx_t'(empty);
            res.took_empty_frame = 1'b1;
            table_valid[empty]   = 1'b1;
            table_page[empty]    = page;
            table_count[empty]   = COUNT_ONE;
            res.new_count        = COUNT_ONE;
        end
        else
        begin
            // eviction: truncated average of the other frames' counts
            sum -= table_count[victim];
            table_page[victim]  = page;
            table_count[victim] = count_t'(sum / (FRAMES - 1));
            res.frame_index     = out_idx_t'(victim);
            res.new_count       = table_count[victim];
        end
        return res;
    endfunction

    // no gap while idling is off; otherwise mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idling_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // pool hits, the all-zero and all-one pages, and fresh random pages
    function automatic page_in_t pick_page();
        int       r;
        page_in_t fresh;
        r = $urandom_range(0, 99);
        if (r < 3)
            return '1;
        if (r < 6)
            return '0;
        if (r < 76)
            return page_pool[$urandom_range(0, pool_n - 1)];
        fresh = $urandom;
        page_pool[$urandom_range(0, pool_n - 1)] = fresh;
        return fresh;
    endfunction

    // offer one request item and wait for the handshake; valid stays high
    // afterwards, so that back-to-back items show no gap in valid
    task automatic send_page(input page_in_t page);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.page_address <= page;
        do
            @(posedge clk);
        while (!req_ch.ready);
        frame_results_q.push_back(lookup_frame(page));
    endtask

    // fills, hits, the all-ones page, single-bit pages, ties and evictions
    task automatic run_directed_test();
        idling_on = 1'b0;
        send_page(32'h0000_0000);
        send_page(32'hFFFF_FFFF);
        send_page(32'h0000_0000);
        send_page(32'h0000_0001);
        send_page(32'h8000_0000);
        send_page(32'hAAAA_AAAA);
        send_page(32'h5555_5555);
        send_page(32'h7FFF_FFFF);
        send_page(32'hFFFF_FFFE);
        // table full now: hits, then evictions among tied counts
        send_page(32'hFFFF_FFFF);
        send_page(32'hFFFF_FFFE);
        send_page(32'h1234_5678);
        send_page(32'h1234_5678);
        send_page(32'hDEAD_BEEF);
        send_page(32'h0000_0001);
        send_page(32'h8000_0000);
        send_page(32'h0000_0000);
        send_page(32'hFFFF_FFFF);
        send_page(32'hDEAD_BEEF);
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic run_backpressure_test();
        idling_on    = 1'b0;
        hold_off_len = HOLD_OFF_LEN;
        for (int i = 0; i < 10; i++)
            send_page((i % 2 == 0) ? 32'h0000_0000 : $urandom);
    endtask

    // random phases, idling switched on and off from phase to phase
    task automatic run_random_test();
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            idling_on = (p % 2 == 0);
            pool_n    = $urandom_range(4, 16);
            for (int i = 0; i < pool_n; i++)
                page_pool[i] = $urandom;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_page(pick_page());
        end
    endtask

    // hit one resident page many times so its count stands far above the rest
    task automatic run_hot_page_test();
        page_in_t page;
        idling_on = 1'b0;
        page      = table_page[0];
        for (int i = 0; i < HOT_HITS; i++)
            send_page(page);
        // evictions next to a hot frame average large counts
        pool_n = 12;
        for (int i = 0; i < pool_n; i++)
            page_pool[i] = $urandom;
        idling_on = 1'b1;
        for (int i = 0; i < 60; i++)
            send_page(pick_page());
    endtask

    // stimulus
    initial
    begin
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.page_address = '0;
        idling_on           = 1'b0;
        hold_off_len        = 0;
        error_count         = 0;
        for (int i = 0; i < FRAMES; i++)
        begin
            table_valid[i] = 1'b0;
            table_page[i]  = '0;
            table_count[i] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed_test();
        run_backpressure_test();
        run_random_test();
        run_hot_page_test();

        req_ch.valid <= 1'b0;
        idling_on = 1'b0;
        while (frame_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (frame_results_q.size() != 0)
        begin
            $error("%0d result items never arrived", frame_results_q.size());
            error_count++;
        end

        $display("covered %0d hits (%0d at saturation), %0d empty-frame fills, %0d evictions",
                 n_hits, n_saturated, n_fills, n_evictions);
        $display("with random gaps, receiver stalls and one long receiver hold-off");
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // receiver: ready runs, random stalls, and the requested long hold-off
    initial
    begin
        resp_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_off_len > 0)
            begin
                resp_ch.ready <= 1'b0;
                repeat (hold_off_len) @(posedge clk);
                hold_off_len = 0;
            end
            else if (idling_on && $urandom_range(0, 3) == 0)
            begin
                resp_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 60)
                                                  : $urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                resp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // result checker, field by field against the oldest prediction
    always @(posedge clk)
    begin : check_results
        frame_result_t want;
        if (rst_n && resp_ch.valid && resp_ch.ready)
        begin
            if (frame_results_q.size() == 0)
            begin
                $error("result item with no request waiting");
                error_count++;
            end
            else
            begin
                want = frame_results_q.pop_front();
                if (want.hit)
                    n_hits++;
                else if (want.took_empty_frame)
                    n_fills++;
                else
                    n_evictions++;
                if (resp_ch.frame_index !== want.frame_index)
                begin
                    $error("frame_index: expected %0d, got %0d",
                           want.frame_index, resp_ch.frame_index);
                    error_count++;
                end
                if (resp_ch.hit !== want.hit)
                begin
                    $error("hit: expected %0b, got %0b", want.hit, resp_ch.hit);
                    error_count++;
                end
                if (resp_ch.took_empty_frame !== want.took_empty_frame)
                begin
                    $error("took_empty_frame: expected %0b, got %0b",
                           want.took_empty_frame, resp_ch.took_empty_frame);
                    error_count++;
                end
                if (resp_ch.new_count !== want.new_count)
                begin
                    $error("new_count: expected %0d, got %0d",
                           want.new_count, resp_ch.new_count);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (resp_ch.valid && resp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
